### rtl/grid_triangle_strip_indexer_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef GRID_TRIANGLE_STRIP_INDEXER_MACROS_SVH
`define GRID_TRIANGLE_STRIP_INDEXER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GTSI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GTSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gtsi_pkg.sv
package gtsi_pkg;

    localparam int unsigned MAX_SIDE   = 256;
    localparam int unsigned SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int unsigned POS_W      = $clog2(MAX_SIDE);
    localparam int unsigned INDEX_W    = 16;
    localparam int unsigned CFG_IDX_W  = 8;

    localparam logic [SIDE_W-1:0] COLS_RESET = SIDE_W'(64);
    localparam logic [SIDE_W-1:0] ROWS_RESET = SIDE_W'(64);
    localparam logic [SIDE_W-1:0] COLS_MIN   = SIDE_W'(1);
    localparam logic [SIDE_W-1:0] ROWS_MIN   = SIDE_W'(2);
    localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        PH_TOP    = 2'd0,
        PH_BOTTOM = 2'd1,
        PH_DEGEN  = 2'd2
    } t_phase;

    // Clamped grid geometry.
    typedef struct packed {
        logic [SIDE_W-1:0] cols;
        logic [SIDE_W-1:0] rows;
    } t_geom;

    typedef struct packed {
        logic               emit;
        logic [INDEX_W-1:0] vertex_index;
        logic               last_index;
    } t_result;

    typedef struct packed {
        logic   done;
        t_phase phase;
    } t_status;

endpackage

### rtl/gtsi_cfg.sv
module gtsi_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [gtsi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gtsi_pkg::SIDE_W-1:0]       i_cfg_data,
    output gtsi_pkg::t_geom                   o_geom
);
    import gtsi_pkg::*;

    logic [SIDE_W-1:0] r_cols;
    logic [SIDE_W-1:0] r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_GRID_COLUMNS) begin
                r_cols <= i_cfg_data;
            end
            if (i_cfg_index == REG_GRID_ROWS) begin
                r_rows <= i_cfg_data;
            end
        end
    end

    // Out-of-range register values are clamped into the legal grid sides.
    always_comb begin
        o_geom.cols = r_cols;
        if (r_cols < COLS_MIN) begin
            o_geom.cols = COLS_MIN;
        end else if (r_cols > SIDE_MAX) begin
            o_geom.cols = SIDE_MAX;
        end
        o_geom.rows = r_rows;
        if (r_rows < ROWS_MIN) begin
            o_geom.rows = ROWS_MIN;
        end else if (r_rows > SIDE_MAX) begin
            o_geom.rows = SIDE_MAX;
        end
    end

endmodule

### rtl/gtsi_core.sv
module gtsi_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_restart,
    input  gtsi_pkg::t_geom   i_geom,
    output gtsi_pkg::t_result o_result,
    output gtsi_pkg::t_status o_status
);
    import gtsi_pkg::*;

    logic [POS_W-1:0]   r_col, n_col;
    logic [POS_W-1:0]   r_row, n_row;
    logic [INDEX_W-1:0] r_base, n_base;
    logic               r_done, n_done;
    t_phase             r_phase, n_phase;

    logic [POS_W-1:0]   cur_col;
    logic [POS_W-1:0]   cur_row;
    logic [INDEX_W-1:0] cur_base;
    logic               cur_done;
    t_phase             cur_phase;
    logic               odd_row;
    logic               row_end;
    logic               strip_end;
    logic [SIDE_W-1:0]  cols_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_base  <= '0;
            r_done  <= 1'b1;
            r_phase <= PH_TOP;
        end else if (i_step) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_base  <= n_base;
            r_done  <= n_done;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        // A restart takes effect before the step that it comes with.
        cur_col   = i_restart ? '0 : r_col;
        cur_row   = i_restart ? '0 : r_row;
        cur_base  = i_restart ? '0 : r_base;
        cur_done  = i_restart ? 1'b0 : r_done;
        cur_phase = i_restart ? PH_TOP : r_phase;

        cols_m1   = i_geom.cols - SIDE_W'(1);
        odd_row   = cur_row[0];
        row_end   = odd_row ? (cur_col == '0) : ({1'b0, cur_col} >= cols_m1);
        strip_end = {1'b0, cur_row} >= (i_geom.rows - SIDE_W'(2));

        n_col   = cur_col;
        n_row   = cur_row;
        n_base  = cur_base;
        n_done  = cur_done;
        n_phase = cur_phase;

        o_result.emit         = !cur_done;
        o_result.last_index   = 1'b0;
        o_result.vertex_index = cur_base + INDEX_W'(cur_col);

        if (!cur_done) begin
            case (cur_phase)
                PH_BOTTOM: begin
                    o_result.vertex_index = cur_base + INDEX_W'(cur_col)
                                          + INDEX_W'(i_geom.cols);
                    if (!row_end) begin
                        n_col   = odd_row ? cur_col - POS_W'(1) : cur_col + POS_W'(1);
                        n_phase = PH_TOP;
                    end else if (strip_end) begin
                        o_result.last_index = 1'b1;
                        n_done  = 1'b1;
                        n_phase = PH_TOP;
                    end else begin
                        n_phase = PH_DEGEN;
                    end
                end
                PH_DEGEN: begin
                    n_row   = cur_row + POS_W'(1);
                    n_base  = cur_base + INDEX_W'(i_geom.cols);
                    n_col   = odd_row ? '0 : cols_m1[POS_W-1:0];
                    n_phase = PH_TOP;
                end
                default: begin
                    n_phase = PH_BOTTOM;
                end
            endcase
        end
    end

    assign o_status.done  = r_done;
    assign o_status.phase = r_phase;

endmodule

### rtl/grid_triangle_strip_indexer.sv
// Channel     | Direction | Payload
// s_axis      | in        | tdata[0] restart, tdata[7:1] zero
// m_axis      | out       | tdata[15:0] vertex_index, tlast last_index
// cfg         | in        | index 0 grid_columns, 1 grid_rows, data[8:0]
//
// One request enters the input register per cycle while tready is high; its index
// is registered in the output register as it advances, through combinational step logic.
// Requests while the strip is finished produce no index but are still consumed.
// Reset is synchronous and active low and leaves the block idle until a restart.
// A stall on m_axis holds the output register and backs up s_axis tready.
`include "grid_triangle_strip_indexer_macros.svh"

module grid_triangle_strip_indexer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [7:0]                          i_s_axis_tdata,   // [0] restart
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [gtsi_pkg::INDEX_W-1:0]        o_m_axis_tdata,   // [15:0] vertex_index
    output logic                                o_m_axis_tlast,   // last_index
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gtsi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gtsi_pkg::SIDE_W-1:0]         i_cfg_data
);
    import gtsi_pkg::*;

    logic               r_in_valid;
    logic               r_in_restart;
    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_index;
    logic               r_out_last;
    logic               advance;
    t_geom              geom;
    t_result            result;
    t_status            status;

    assign o_cfg_ready = 1'b1;

    gtsi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom)
    );

    // The held request moves on once the output register is free or being drained.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    gtsi_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_restart (r_in_restart),
        .i_geom    (geom),
        .o_result  (result),
        .o_status  (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_restart <= i_s_axis_tdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.emit;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_index <= result.vertex_index;
            r_out_last  <= result.last_index;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_index;
    assign o_m_axis_tlast  = r_out_last;

    `GTSI_ASSERT_NEXT(a_restart_emits, i_clk, i_rst_n, advance && r_in_restart, r_out_valid, "restart request produced no index")
    `GTSI_ASSERT_NOW(a_last_ends_strip, i_clk, i_rst_n, r_out_valid && r_out_last && !r_in_valid, status.done, "last index shown while strip still running")
    `GTSI_ASSERT_NOW(a_geom_clamped, i_clk, i_rst_n, 1'b1, (geom.cols != '0) && (geom.cols <= SIDE_MAX) && (geom.rows >= ROWS_MIN) && (geom.rows <= SIDE_MAX), "grid geometry outside clamped range")

endmodule
